@@ sv/assert_macros.svh @@
// Assertion shorthands; every user has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SMX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/smx_pkg.sv @@
package smx_pkg;

  localparam int STACK_WORDS_DEF   = 256;
  localparam int MEMORY_WORDS_DEF  = 256;
  localparam int PROGRAM_WORDS_DEF = 256;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = 6;

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_STORE  = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_REM    = 4'd7,
    OP_CMP    = 4'd8,
    OP_JUMP   = 4'd9,
    OP_BRANCH = 4'd10,
    OP_HALT   = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_BADEND   = 3'd3,
    ST_OVERFLOW = 3'd4
  } stat_t;

  typedef enum logic [3:0] {
    K_PUSH, K_LOAD, K_STORE, K_ALU, K_DIV, K_JUMP, K_BRANCH, K_HALT, K_NOP
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_EXEC, S_LOAD, S_DIV, S_DONE
  } st_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] immediate;
    logic [7:0]         mem_address;
    logic [7:0]         jump_target;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               branch_taken;
    logic [7:0]         branch_index;
    logic               halted;
    logic signed [31:0] top_value;
    logic [8:0]         stack_depth;
  } out_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         operation;
    logic signed [31:0] immediate;
    logic [7:0]         mem_address;
    logic [7:0]         jump_target;
  } dec_t;

endpackage

@@ sv/smx_div.sv @@
module smx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  import smx_pkg::*;

  `include "assert_macros.svh"

  logic [DIV_CW-1:0] cnt;
  logic [31:0]       q;
  logic [31:0]       r;
  logic [31:0]       d;
  logic              neg_q;
  logic              neg_r;
  logic [32:0]       shifted;
  logic [32:0]       trial;

  // one restoring step per cycle on magnitudes
  assign shifted = {r, q[31]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[31] ? -dividend : dividend;
      d     <= divisor[31] ? -divisor : divisor;
      r     <= '0;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= shifted[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quot = neg_q ? -q : q;
  assign rem  = neg_r ? -r : r;

  `SMX_ASSERT_IMP(a_no_restart, start, !busy)

endmodule

@@ sv/smx_front.sv @@
module smx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  smx_pkg::in_word_t cmd,
  output logic              q_valid,
  output smx_pkg::dec_t     q_head,
  input  logic              q_pop
);
  import smx_pkg::*;

  `include "assert_macros.svh"

  dec_t       slots [2];
  logic       wr;
  logic       rd;
  logic [1:0] fill;
  logic       push;

  function automatic dec_t classify(in_word_t w);
    dec_t o;
    o.operation   = w.operation;
    o.immediate   = w.immediate;
    o.mem_address = w.mem_address;
    o.jump_target = w.jump_target;
    case (w.operation)
      OP_PUSH:   o.kind = K_PUSH;
      OP_LOAD:   o.kind = K_LOAD;
      OP_STORE:  o.kind = K_STORE;
      OP_ADD:    o.kind = K_ALU;
      OP_SUB:    o.kind = K_ALU;
      OP_MUL:    o.kind = K_ALU;
      OP_CMP:    o.kind = K_ALU;
      OP_DIV:    o.kind = K_DIV;
      OP_REM:    o.kind = K_DIV;
      OP_JUMP:   o.kind = K_JUMP;
      OP_BRANCH: o.kind = K_BRANCH;
      OP_HALT:   o.kind = K_HALT;
      default:   o.kind = K_NOP;
    endcase
    return o;
  endfunction

  assign cmd_ready = (fill != 2'd2) && !hold;
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (fill != 2'd0);
  assign q_head    = slots[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr   <= 1'b0;
      rd   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (q_pop) rd <= ~rd;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr] <= classify(cmd);
  end

  `SMX_ASSERT_IMP(a_pop_nonempty, q_pop, fill != 2'd0)

endmodule

@@ sv/smx_back.sv @@
module smx_back #(
  parameter int STACK_WORDS   = smx_pkg::STACK_WORDS_DEF,
  parameter int MEMORY_WORDS  = smx_pkg::MEMORY_WORDS_DEF,
  parameter int PROGRAM_WORDS = smx_pkg::PROGRAM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  output logic               hold,
  input  logic               q_valid,
  input  smx_pkg::dec_t      q_head,
  output logic               q_pop,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output smx_pkg::out_word_t rsp
);
  import smx_pkg::*;

  `include "assert_macros.svh"

  localparam int CW  = $clog2(STACK_WORDS + 1);
  localparam int SAW = $clog2(STACK_WORDS);
  localparam int MAW = $clog2(MEMORY_WORDS);
  localparam int XW  = ((MAW > 8) ? MAW : 8) + 1;
  localparam int DW  = (CW > 9) ? CW : 9;

  st_t  state, state_next;

  // top two entries live in registers, the rest in smem at their own index
  logic [31:0]   tos, tos_next;
  logic [31:0]   nos, nos_next;
  logic [CW-1:0] count, count_next;
  logic          fill_one, fill_one_next;
  logic          fill_two, fill_two_next;
  stat_t         st_code, st_next;
  logic          taken, taken_next;
  logic [7:0]    bidx, bidx_next;
  logic          halted, halted_next;
  logic          rem_sel, rem_sel_next;
  logic          ld_ok, ld_ok_next;
  logic [MAW-1:0] clr_idx, clr_idx_next;
  out_word_t     res, res_next;
  logic          res_valid, res_valid_next;

  logic [31:0]   smem [STACK_WORDS];
  logic [31:0]   rd_a, rd_b;
  logic          sm_we;
  logic [CW-1:0] c_m2, c_m3, c_m4;

  logic [31:0]    dmem [MEMORY_WORDS];
  logic [31:0]    dm_rd;
  logic           dm_we;
  logic [MAW-1:0] dm_waddr;
  logic [31:0]    dm_wdata;
  logic [XW-1:0]  addr_ext;
  logic           addr_ok;
  logic [MAW-1:0] h_idx;

  logic [7:0]    mod_tab [256];
  logic [31:0]   alu;
  logic          full;
  logic          div_start, div_busy, div_done;
  logic [31:0]   div_q, div_r;
  logic [DW-1:0] depth_ext;

  for (genvar gi = 0; gi < 256; gi++) begin : g_mod
    assign mod_tab[gi] = 8'(gi % PROGRAM_WORDS);
  end

  assign full     = (count == CW'(STACK_WORDS));
  assign c_m2     = count - CW'(2);
  assign c_m3     = count - CW'(3);
  assign c_m4     = count - CW'(4);
  assign addr_ext = XW'(q_head.mem_address);
  assign addr_ok  = (addr_ext < XW'(MEMORY_WORDS));
  assign h_idx    = addr_ext[MAW-1:0];
  assign hold     = (state == S_CLEAR);

  always_comb begin
    case (q_head.operation)
      OP_ADD:  alu = nos + tos;
      OP_SUB:  alu = nos - tos;
      OP_MUL:  alu = nos * tos;
      default: begin
        if ($signed(nos) > $signed(tos)) alu = 32'd1;
        else if (nos == tos)             alu = 32'd0;
        else                             alu = '1;
      end
    endcase
  end

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nos),
    .divisor  (tos),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == MAW'(MEMORY_WORDS - 1)) state_next = S_EXEC;
      S_EXEC: begin
        if (q_valid) begin
          if (q_head.kind == K_LOAD && !full) state_next = S_LOAD;
          else if (q_head.kind == K_DIV && count >= CW'(2) && tos != '0)
            state_next = S_DIV;
          else state_next = S_DONE;
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_DIV:   if (div_done) state_next = S_DONE;
      S_DONE:  if (!res_valid || rsp_ready) state_next = S_EXEC;
      default: state_next = S_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    tos_next       = tos;
    nos_next       = nos;
    count_next     = count;
    fill_one_next  = 1'b0;
    fill_two_next  = 1'b0;
    st_next        = st_code;
    taken_next     = taken;
    bidx_next      = bidx;
    halted_next    = halted;
    rem_sel_next   = rem_sel;
    ld_ok_next     = ld_ok;
    clr_idx_next   = clr_idx;
    res_next       = res;
    res_valid_next = res_valid && !rsp_ready;
    sm_we          = 1'b0;
    dm_we          = 1'b0;
    dm_waddr       = h_idx;
    dm_wdata       = tos;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    depth_ext      = DW'(count);
    case (state)
      S_CLEAR: begin
        dm_we        = 1'b1;
        dm_waddr     = clr_idx;
        dm_wdata     = '0;
        clr_idx_next = clr_idx + MAW'(1);
      end
      S_EXEC: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          st_next     = ST_OK;
          taken_next  = 1'b0;
          bidx_next   = 8'd0;
          halted_next = 1'b0;
          case (q_head.kind)
            K_PUSH: begin
              if (full) st_next = ST_OVERFLOW;
              else begin
                sm_we      = (count >= CW'(2));
                nos_next   = tos;
                tos_next   = q_head.immediate;
                count_next = count + CW'(1);
              end
            end
            K_LOAD: begin
              if (full) st_next = ST_OVERFLOW;
              ld_ok_next = addr_ok;
            end
            K_STORE: begin
              if (count == '0) st_next = ST_FEW;
              else begin
                dm_we         = addr_ok;
                tos_next      = nos;
                fill_one_next = 1'b1;
                count_next    = count - CW'(1);
              end
            end
            K_ALU: begin
              if (count < CW'(2)) st_next = ST_FEW;
              else begin
                tos_next      = alu;
                fill_one_next = 1'b1;
                count_next    = count - CW'(1);
              end
            end
            K_DIV: begin
              if (count < CW'(2)) st_next = ST_FEW;
              else if (tos == '0) begin
                // both operands consumed, nothing pushed
                st_next       = ST_DIVZERO;
                fill_two_next = 1'b1;
                count_next    = count - CW'(2);
              end else begin
                div_start    = 1'b1;
                rem_sel_next = (q_head.operation == OP_REM);
              end
            end
            K_JUMP: begin
              taken_next = 1'b1;
              bidx_next  = mod_tab[q_head.jump_target];
            end
            K_BRANCH: begin
              if (count == '0) st_next = ST_FEW;
              else begin
                tos_next      = nos;
                fill_one_next = 1'b1;
                count_next    = count - CW'(1);
                if (tos != '0) begin
                  taken_next = 1'b1;
                  bidx_next  = mod_tab[q_head.jump_target];
                end
              end
            end
            K_HALT: begin
              halted_next = 1'b1;
              if (count == '0) st_next = ST_FEW;
              else begin
                tos_next      = nos;
                fill_one_next = 1'b1;
                count_next    = count - CW'(1);
                if (tos != '0) st_next = ST_BADEND;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        sm_we      = (count >= CW'(2));
        nos_next   = tos;
        tos_next   = ld_ok ? dm_rd : '0;
        count_next = count + CW'(1);
      end
      S_DIV: begin
        if (div_done) begin
          tos_next      = rem_sel ? div_r : div_q;
          fill_one_next = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      S_DONE: begin
        // refill from the read issued in the previous cycle
        if (fill_two) begin
          tos_next = rd_a;
          nos_next = rd_b;
        end else if (fill_one) begin
          nos_next = rd_a;
        end
        if (!res_valid || rsp_ready) begin
          res_valid_next        = 1'b1;
          res_next.status       = st_code;
          res_next.branch_taken = taken;
          res_next.branch_index = bidx;
          res_next.halted       = halted;
          res_next.top_value    = (count == '0) ? '0 : tos_next;
          res_next.stack_depth  = depth_ext[8:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[c_m2[SAW-1:0]] <= nos;
    rd_a <= smem[c_m3[SAW-1:0]];
    rd_b <= smem[c_m4[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    dm_rd <= dmem[h_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      fill_one  <= 1'b0;
      fill_two  <= 1'b0;
      clr_idx   <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      fill_one  <= fill_one_next;
      fill_two  <= fill_two_next;
      clr_idx   <= clr_idx_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tos     <= tos_next;
    nos     <= nos_next;
    st_code <= st_next;
    taken   <= taken_next;
    bidx    <= bidx_next;
    halted  <= halted_next;
    rem_sel <= rem_sel_next;
    ld_ok   <= ld_ok_next;
    res     <= res_next;
  end

  assign rsp_valid = res_valid;
  assign rsp       = res;

  `SMX_ASSERT_IMP(a_no_pop_clear, state == S_CLEAR, !q_pop)
  `SMX_ASSERT_NEXT(a_div_to_done, (state == S_DIV) && div_done, state == S_DONE)
  `SMX_ASSERT_IMP(a_rsp_from_done, $rose(res_valid), $past(state) == S_DONE)
  `SMX_ASSERT_IMP(a_div_idle_exec, state == S_EXEC, !div_busy)

endmodule

@@ sv/stack_machine_execute_unit.sv @@
// Stack machine execute unit: each command word runs one instruction (push,
// load, store, add, sub, mul, div, rem, cmp, jump, branch, halt) on an
// operand stack of 32-bit words and a word-addressed data memory, and gives
// one response word with status, branch decision, top of stack and depth.
// After reset the data memory is cleared one word per cycle, during which
// cmd_ready stays low. Most instructions then pass through the execute
// state and then a stack refill and response state; load adds a state for
// the registered data memory read, and div/rem wait in a state for the
// one-bit-per-cycle divider. A two-word command queue and a response
// register let both sides stall independently.
module stack_machine_execute_unit #(
  parameter int STACK_WORDS   = smx_pkg::STACK_WORDS_DEF,
  parameter int MEMORY_WORDS  = smx_pkg::MEMORY_WORDS_DEF,
  parameter int PROGRAM_WORDS = smx_pkg::PROGRAM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  smx_pkg::in_word_t  cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output smx_pkg::out_word_t rsp
);
  import smx_pkg::*;

  logic q_valid;
  dec_t q_head;
  logic q_pop;
  logic hold;

  // front: accept, classify, queue
  smx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (hold),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // back: stack, memory, divider, response register
  smx_back #(
    .STACK_WORDS   (STACK_WORDS),
    .MEMORY_WORDS  (MEMORY_WORDS),
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .hold      (hold),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
